FILE: rtl/core/gisp_pkg.sv
// Shared types, category codes and the classify function for the instruction predecoder.
package gisp_pkg;

    // Default width of the saturating instruction counter
    localparam int COUNT_BITS_DEF = 16;
    localparam int INDEX_W        = 16;

    // Category codes
    localparam logic [3:0] CAT_SOPP    = 4'd0;
    localparam logic [3:0] CAT_SOP1    = 4'd1;
    localparam logic [3:0] CAT_SOPC    = 4'd2;
    localparam logic [3:0] CAT_SOP2    = 4'd3;
    localparam logic [3:0] CAT_EXP     = 4'd4;
    localparam logic [3:0] CAT_SMEM    = 4'd5;
    localparam logic [3:0] CAT_VOP1    = 4'd6;
    localparam logic [3:0] CAT_VOP3    = 4'd7;
    localparam logic [3:0] CAT_VOP2    = 4'd8;
    localparam logic [3:0] CAT_UNKNOWN = 4'd9;

    // Encoding prefixes
    localparam logic [8:0] ENC_SOPP = 9'b101111110;
    localparam logic [8:0] ENC_SOP1 = 9'b101111101;
    localparam logic [8:0] ENC_SOPC = 9'b101111111;
    localparam logic [1:0] ENC_SOP2 = 2'b10;
    localparam logic [5:0] ENC_EXP  = 6'b111110;
    localparam logic [5:0] ENC_SMEM = 6'b110000;
    localparam logic [6:0] ENC_VOP1 = 7'b0111111;
    localparam logic [5:0] ENC_VOP3 = 6'b110100;

    // SOPP opcode that ends the program
    localparam logic [9:0] OP_ENDPGM = 10'd1;

    // Input word
    typedef struct packed {
        logic [31:0] in_word;
        logic        buffer_last;
    } gisp_in_t;

    // Decoded result word
    typedef struct packed {
        logic [3:0]         category;
        logic [9:0]         op_code;
        logic [7:0]         dest_reg;
        logic [8:0]         source_a;
        logic [8:0]         source_b;
        logic [8:0]         source_c;
        logic               two_words;
        logic [31:0]        word_first;
        logic [31:0]        word_second;
        logic               emit_placeholder;
        logic               program_end;
        logic [INDEX_W-1:0] insn_index;
    } gisp_out_t;

    // Priority classification on the top bits of a first word
    function automatic logic [3:0] classify(input logic [31:0] w);
        logic [3:0] cat;
        if (w[31:23] == ENC_SOPP)      cat = CAT_SOPP;
        else if (w[31:23] == ENC_SOP1) cat = CAT_SOP1;
        else if (w[31:23] == ENC_SOPC) cat = CAT_SOPC;
        else if (w[31:30] == ENC_SOP2) cat = CAT_SOP2;
        else if (w[31:26] == ENC_EXP)  cat = CAT_EXP;
        else if (w[31:26] == ENC_SMEM) cat = CAT_SMEM;
        else if (w[31:25] == ENC_VOP1) cat = CAT_VOP1;
        else if (w[31:26] == ENC_VOP3) cat = CAT_VOP3;
        else if (!w[31])               cat = CAT_VOP2;
        else                           cat = CAT_UNKNOWN;
        return cat;
    endfunction

    // Categories that carry a second word
    function automatic logic needs_second(input logic [3:0] cat);
        return (cat == CAT_EXP) || (cat == CAT_SMEM) || (cat == CAT_VOP3);
    endfunction

endpackage

FILE: rtl/core/gisp_decode.sv
// Field extraction for one instruction: category, opcode, operands and flags.
module gisp_decode
    import gisp_pkg::*;
(
    input  logic [31:0]        first_word,
    input  logic               two,
    input  logic [31:0]        second_word,
    input  logic [INDEX_W-1:0] index,
    output gisp_out_t          result
);

    logic [3:0] cat;
    logic [9:0] op;
    logic [7:0] dst;
    logic [8:0] sa;
    logic [8:0] sb;
    logic [8:0] sc;

    assign cat = classify(first_word);

    // Per-category field layout
    always_comb
    begin
        op  = '0;
        dst = '0;
        sa  = '0;
        sb  = '0;
        sc  = '0;
        case (cat)
            CAT_SOPP:
            begin
                op = {3'b0, first_word[22:16]};
            end
            CAT_SOP1:
            begin
                op  = {2'b0, first_word[15:8]};
                dst = {1'b0, first_word[22:16]};
                sa  = {1'b0, first_word[7:0]};
            end
            CAT_SOPC:
            begin
                op = {3'b0, first_word[22:16]};
                sa = {1'b0, first_word[7:0]};
                sb = {1'b0, first_word[15:8]};
            end
            CAT_SOP2:
            begin
                op  = {3'b0, first_word[29:23]};
                dst = {1'b0, first_word[22:16]};
                sa  = {1'b0, first_word[7:0]};
                sb  = {1'b0, first_word[15:8]};
            end
            CAT_EXP:
            begin
                op = {4'b0, first_word[9:4]};
            end
            CAT_SMEM:
            begin
                op = {4'b0, first_word[23:18]};
            end
            CAT_VOP1:
            begin
                op  = {2'b0, first_word[16:9]};
                dst = first_word[24:17];
                sa  = first_word[8:0];
            end
            CAT_VOP3:
            begin
                op  = first_word[25:16];
                dst = first_word[7:0];
                if (two)
                begin
                    sa = second_word[8:0];
                    sb = second_word[17:9];
                    sc = second_word[26:18];
                end
            end
            CAT_VOP2:
            begin
                op  = {4'b0, first_word[30:25]};
                dst = first_word[24:17];
                sa  = first_word[8:0];
                sb  = {1'b0, first_word[16:9]};
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    // Pack the result word
    always_comb
    begin
        result.category         = cat;
        result.op_code          = op;
        result.dest_reg         = dst;
        result.source_a         = sa;
        result.source_b         = sb;
        result.source_c         = sc;
        result.two_words        = two;
        result.word_first       = first_word;
        result.word_second      = two ? second_word : 32'd0;
        result.emit_placeholder = (cat == CAT_SOP1) || (cat == CAT_SOP2) ||
                                  (cat == CAT_EXP)  || (cat == CAT_SMEM) ||
                                  (cat == CAT_VOP1) || (cat == CAT_VOP2);
        result.program_end      = (cat == CAT_SOPP) && (op == OP_ENDPGM);
        result.insn_index       = index;
    end

endmodule

FILE: rtl/core/gpu_instruction_stream_predecoder.sv
// Top level: input register, stream sequencing state, decode and result register.
// A word waits in the input register until the result register is free; then its
// result is registered. Throughput: one word per cycle while out_ready holds.
// EXP, SMEM and VOP3 give one result after their second word, or alone if buffer_last.
// Reset clears valid flags, the second-word and program-end flags and the counter.
// No clearing pass; the block takes words in the first cycle after reset.
module gpu_instruction_stream_predecoder
    import gisp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gisp_in_t  in_data,
    input  logic      out_ready,
    output logic      out_valid,
    output gisp_out_t out_data
);

    localparam int CW = (COUNT_BITS > INDEX_W) ? COUNT_BITS : INDEX_W;

    // Input register
    logic     s1_valid_reg;
    gisp_in_t s1_data_reg;

    // Stream state
    logic                  awaiting_reg;
    logic                  awaiting_next;
    logic [31:0]           held_reg;
    logic                  ended_reg;
    logic                  ended_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    // Result register
    logic      out_valid_reg;
    gisp_out_t out_data_reg;

    logic               out_free;
    logic               s1_adv;
    logic               produce;
    logic               hold_first;
    logic [3:0]         in_cat;
    logic [CW-1:0]      count_ext;
    logic [INDEX_W-1:0] index;
    logic [31:0]        dec_first;
    logic [31:0]        dec_second;
    gisp_out_t          dec_result;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Word sequencing: ignore, hold a first word, or produce a result
    assign in_cat     = classify(s1_data_reg.in_word);
    assign hold_first = !ended_reg && !awaiting_reg && needs_second(in_cat)
                        && !s1_data_reg.buffer_last;
    assign produce    = !ended_reg && !hold_first;

    assign dec_first  = awaiting_reg ? held_reg : s1_data_reg.in_word;
    assign dec_second = awaiting_reg ? s1_data_reg.in_word : 32'd0;

    // Saturated index view of the counter
    assign count_ext = CW'(count_reg);
    assign index     = (count_ext > CW'(17'h0FFFF)) ? {INDEX_W{1'b1}} : count_ext[INDEX_W-1:0];

    gisp_decode u_decode
    (
        .first_word  (dec_first),
        .two         (awaiting_reg),
        .second_word (dec_second),
        .index       (index),
        .result      (dec_result)
    );

    // Next stream state
    always_comb
    begin
        awaiting_next = awaiting_reg;
        ended_next    = ended_reg;
        count_next    = count_reg;
        if (produce)
        begin
            awaiting_next = 1'b0;
            if (count_reg != {COUNT_BITS{1'b1}})
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
            if (dec_result.program_end)
            begin
                ended_next = 1'b1;
            end
        end
        else if (hold_first)
        begin
            awaiting_next = 1'b1;
        end
        if (s1_data_reg.buffer_last)
        begin
            awaiting_next = 1'b0;
            ended_next    = 1'b0;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            ended_reg    <= 1'b0;
            count_reg    <= '0;
        end
        else if (s1_adv)
        begin
            awaiting_reg <= awaiting_next;
            ended_reg    <= ended_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && hold_first)
        begin
            held_reg <= s1_data_reg.in_word;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && produce)
        begin
            out_data_reg <= dec_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(awaiting_reg && ended_reg))
        else $error("second-word wait while program ended");

    a_end_latches: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && produce && dec_result.program_end && !s1_data_reg.buffer_last
        |=> ended_reg)
        else $error("program end not recorded");

    a_ignored_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && ended_reg |=> !out_valid_reg)
        else $error("result given after program end");

    a_two_word_cat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.two_words |->
        (out_data_reg.category == CAT_EXP) || (out_data_reg.category == CAT_SMEM) ||
        (out_data_reg.category == CAT_VOP3))
        else $error("two-word result with single-word category");

endmodule
